// ----- sv/tcsq_pkg.sv -----
`default_nettype none
// Package for the two-class sorted queue: sizes, command and status codes,
// cell operations and the controller state type. No dependencies.
package tcsq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int VALUE_W     = 16;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int COUNT_W     = 5;

    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_REMOVE  = 2'd1;
    localparam logic [1:0] CMD_DEQUEUE = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_EMPTY     = 2'd3;

    localparam logic CLASS_PRIO    = 1'b0;
    localparam logic CLASS_REGULAR = 1'b1;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op             op;
        logic [VALUE_W-1:0]   value;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage
`default_nettype wire

// ----- sv/tcsq_cell.sv -----
`default_nettype none
// One entry of a sorted queue. It compares its value with the broadcast
// value and takes its neighbor's value on insert, remove or shift. Uses tcsq_pkg.
module tcsq_cell (
    input  wire                          i_clk,
    input  tcsq_pkg::t_cell_ctl          i_ctl,
    input  wire                          i_occ,
    input  wire                          i_left_le,
    input  wire [tcsq_pkg::VALUE_W-1:0]  i_left_value,
    input  wire [tcsq_pkg::VALUE_W-1:0]  i_right_value,
    output logic [tcsq_pkg::VALUE_W-1:0] o_value,
    output logic                         o_le,
    output logic                         o_eq
);
    import tcsq_pkg::*;

    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] n_value;
    logic               w_lt;

    assign w_lt    = i_occ && (r_value < i_ctl.value);
    assign o_eq    = i_occ && (r_value == i_ctl.value);
    assign o_le    = w_lt || o_eq;
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        case (i_ctl.op)
            OP_INSERT: begin
                // The first cell past the insertion point takes the new value;
                // the cells after it move one place to the right.
                if (!o_le) begin
                    n_value = i_left_le ? i_ctl.value : i_left_value;
                end
            end
            OP_REMOVE: begin
                if (!w_lt) begin
                    n_value = i_right_value;
                end
            end
            OP_SHIFT: n_value = i_right_value;
            default:  n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule
`default_nettype wire

// ----- sv/tcsq_chain.sv -----
`default_nettype none
// A row of sorted cells forming one class queue. Occupancy comes from the
// fill count. Uses tcsq_pkg and tcsq_cell.
module tcsq_chain (
    input  wire                          i_clk,
    input  tcsq_pkg::t_cell_ctl          i_ctl,
    input  wire [tcsq_pkg::FILL_W-1:0]   i_fill,
    output logic [tcsq_pkg::VALUE_W-1:0] o_head,
    output logic                         o_found
);
    import tcsq_pkg::*;

    logic [VALUE_W-1:0] w_value [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_le;
    logic [QUEUE_DEPTH-1:0] w_eq;
    logic [QUEUE_DEPTH-1:0] w_occ;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic               w_left_le;
            logic [VALUE_W-1:0] w_left_value;
            logic [VALUE_W-1:0] w_right_value;

            assign w_occ[g] = (i_fill > FILL_W'(g));

            if (g == 0) begin : g_first
                assign w_left_le    = 1'b1;
                assign w_left_value = '0;
            end else begin : g_inner
                assign w_left_le    = w_le[g-1];
                assign w_left_value = w_value[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign w_right_value = '0;
            end else begin : g_body
                assign w_right_value = w_value[g+1];
            end

            tcsq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (i_ctl),
                .i_occ         (w_occ[g]),
                .i_left_le     (w_left_le),
                .i_left_value  (w_left_value),
                .i_right_value (w_right_value),
                .o_value       (w_value[g]),
                .o_le          (w_le[g]),
                .o_eq          (w_eq[g])
            );
        end
    endgenerate

    assign o_head  = w_value[0];
    assign o_found = |w_eq;

endmodule
`default_nettype wire

// ----- sv/two_class_sorted_queue_alternating_unit.sv -----
`default_nettype none
// Top level of the two-class sorted queue with alternating dequeue service.
// Uses tcsq_pkg and two tcsq_chain rows, one per class.
//
//   channel   handshake           payload
//   command   start, busy         i_cmd, i_req_class, i_req_value
//   result    o_done (strobe)     o_status, o_out_class, o_out_value,
//                                 o_prio_count, o_reg_count
//
// A command transfers when start is high and busy is low. The next cycle
// compares it against every cell of both rows at once and updates the rows;
// the registered result strobe follows in the cycle after that, and a new
// command may transfer in the strobe cycle. Reset empties both queues and
// makes the priority class the first one served. Results cannot be stalled.
module two_class_sorted_queue_alternating_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire [1:0]                    i_cmd,
    input  wire                          i_req_class,
    input  wire [tcsq_pkg::VALUE_W-1:0]  i_req_value,
    output logic                         o_done,
    output logic [1:0]                   o_status,
    output logic                         o_out_class,
    output logic [tcsq_pkg::VALUE_W-1:0] o_out_value,
    output logic [tcsq_pkg::COUNT_W-1:0] o_prio_count,
    output logic [tcsq_pkg::COUNT_W-1:0] o_reg_count
);
    import tcsq_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [1:0]         r_cmd;
    logic               r_class;
    logic [VALUE_W-1:0] r_value;

    logic [FILL_W-1:0]  r_prio_fill;
    logic [FILL_W-1:0]  n_prio_fill;
    logic [FILL_W-1:0]  r_reg_fill;
    logic [FILL_W-1:0]  n_reg_fill;
    logic               r_last_reg;
    logic               n_last_reg;

    logic               r_done;
    logic [1:0]         r_status;
    logic [1:0]         n_status;
    logic               r_out_class;
    logic               n_out_class;
    logic [VALUE_W-1:0] r_out_value;
    logic [VALUE_W-1:0] n_out_value;

    logic               w_accept;
    logic               w_exec;
    t_cell_ctl          w_prio_ctl;
    t_cell_ctl          w_reg_ctl;
    logic [VALUE_W-1:0] w_prio_head;
    logic [VALUE_W-1:0] w_reg_head;
    logic               w_prio_found;
    logic               w_reg_found;
    logic               w_prio_empty;
    logic               w_reg_empty;
    logic               w_serve_reg;

    assign w_accept     = start && !busy;
    assign w_prio_empty = (r_prio_fill == '0);
    assign w_reg_empty  = (r_reg_fill == '0);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) begin
                n_state = ST_EXEC;
            end
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        busy   = 1'b0;
        w_exec = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                busy   = 1'b0;
                w_exec = 1'b0;
            end
            ST_EXEC: begin
                busy   = 1'b1;
                w_exec = 1'b1;
            end
            default: begin
                busy   = 1'b0;
                w_exec = 1'b0;
            end
        endcase
    end

    tcsq_chain u_prio_chain (
        .i_clk   (i_clk),
        .i_ctl   (w_prio_ctl),
        .i_fill  (r_prio_fill),
        .o_head  (w_prio_head),
        .o_found (w_prio_found)
    );

    tcsq_chain u_reg_chain (
        .i_clk   (i_clk),
        .i_ctl   (w_reg_ctl),
        .i_fill  (r_reg_fill),
        .o_head  (w_reg_head),
        .o_found (w_reg_found)
    );

    assign w_serve_reg = r_last_reg ? w_prio_empty : !w_reg_empty;

    // Command execution: row operations, new fill counts and the result.
    always_comb begin
        w_prio_ctl.op    = OP_HOLD;
        w_prio_ctl.value = r_value;
        w_reg_ctl.op     = OP_HOLD;
        w_reg_ctl.value  = r_value;
        n_prio_fill      = r_prio_fill;
        n_reg_fill       = r_reg_fill;
        n_last_reg       = r_last_reg;
        n_status         = STAT_OK;
        n_out_class      = CLASS_PRIO;
        n_out_value      = '0;
        if (w_exec) begin
            unique case (r_cmd)
                CMD_INSERT: begin
                    if (r_class == CLASS_REGULAR) begin
                        if (r_reg_fill == FILL_W'(QUEUE_DEPTH)) begin
                            n_status = STAT_FULL;
                        end else begin
                            w_reg_ctl.op = OP_INSERT;
                            n_reg_fill   = r_reg_fill + 1'b1;
                        end
                    end else begin
                        if (r_prio_fill == FILL_W'(QUEUE_DEPTH)) begin
                            n_status = STAT_FULL;
                        end else begin
                            w_prio_ctl.op = OP_INSERT;
                            n_prio_fill   = r_prio_fill + 1'b1;
                        end
                    end
                end
                CMD_REMOVE: begin
                    if (r_class == CLASS_REGULAR) begin
                        if (w_reg_found) begin
                            w_reg_ctl.op = OP_REMOVE;
                            n_reg_fill   = r_reg_fill - 1'b1;
                        end else begin
                            n_status = STAT_NOT_FOUND;
                        end
                    end else begin
                        if (w_prio_found) begin
                            w_prio_ctl.op = OP_REMOVE;
                            n_prio_fill   = r_prio_fill - 1'b1;
                        end else begin
                            n_status = STAT_NOT_FOUND;
                        end
                    end
                end
                CMD_DEQUEUE: begin
                    if (w_prio_empty && w_reg_empty) begin
                        n_status = STAT_EMPTY;
                    end else if (w_serve_reg) begin
                        w_reg_ctl.op = OP_SHIFT;
                        n_reg_fill   = r_reg_fill - 1'b1;
                        n_out_class  = CLASS_REGULAR;
                        n_out_value  = w_reg_head;
                        n_last_reg   = 1'b1;
                    end else begin
                        w_prio_ctl.op = OP_SHIFT;
                        n_prio_fill   = r_prio_fill - 1'b1;
                        n_out_class   = CLASS_PRIO;
                        n_out_value   = w_prio_head;
                        n_last_reg    = 1'b0;
                    end
                end
                default: n_status = STAT_OK;
            endcase
            // Once both queues drain, the next service starts with priority.
            if (n_prio_fill == '0 && n_reg_fill == '0) begin
                n_last_reg = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_prio_fill <= '0;
            r_reg_fill  <= '0;
            r_last_reg  <= 1'b1;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prio_fill <= n_prio_fill;
            r_reg_fill  <= n_reg_fill;
            r_last_reg  <= n_last_reg;
            r_done      <= w_exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_cmd;
            r_class <= i_req_class;
            r_value <= i_req_value;
        end
        if (w_exec) begin
            r_status    <= n_status;
            r_out_class <= n_out_class;
            r_out_value <= n_out_value;
        end
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_out_class  = r_out_class;
    assign o_out_value  = r_out_value;
    assign o_prio_count = COUNT_W'(r_prio_fill);
    assign o_reg_count  = COUNT_W'(r_reg_fill);

endmodule
`default_nettype wire

// ----- test/tcsq_order_checker.sv -----
`timescale 1ns / 100ps
// Checker for the two-class sorted queue: watches the command and result
// channels, predicts every result and compares it field by field. Uses tcsq_pkg.
module tcsq_order_checker (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire                          i_busy,
    input  wire [1:0]                    i_cmd,
    input  wire                          i_req_class,
    input  wire [tcsq_pkg::VALUE_W-1:0]  i_req_value,
    input  wire                          i_done,
    input  wire [1:0]                    i_status,
    input  wire                          i_out_class,
    input  wire [tcsq_pkg::VALUE_W-1:0]  i_out_value,
    input  wire [tcsq_pkg::COUNT_W-1:0]  i_prio_count,
    input  wire [tcsq_pkg::COUNT_W-1:0]  i_reg_count,
    output int                           o_fail_count,
    output int                           o_pending
);
    import tcsq_pkg::*;

    typedef struct packed {
        logic [1:0]         status;
        logic               out_class;
        logic [VALUE_W-1:0] out_value;
        logic [COUNT_W-1:0] prio_count;
        logic [COUNT_W-1:0] reg_count;
    } t_queue_reply;

    // Shadow of both sorted rows, indexed by class.
    logic [VALUE_W-1:0] held [2][QUEUE_DEPTH];
    int unsigned        fill [2];
    logic               last_was_regular;
    t_queue_reply       awaited_replies [$];
    t_queue_reply       oldest;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        o_fail_count++;
        $display("%0t checker: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    function automatic void drop_entry(logic cls, int pos);
        int i;
        for (i = pos; i + 1 < int'(fill[cls]); i++) begin
            held[cls][i] = held[cls][i + 1];
        end
        fill[cls]--;
    endfunction

    function automatic t_queue_reply serve_command(logic [1:0] cmd, logic cls,
                                                   logic [VALUE_W-1:0] val);
        t_queue_reply r;
        int           pos;
        int           i;
        logic         serve_reg;
        r = '0;
        r.status = STAT_OK;
        case (cmd)
            CMD_INSERT: begin
                if (fill[cls] >= QUEUE_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    // Equal values stay ahead of the new entry.
                    pos = 0;
                    while (pos < int'(fill[cls]) && held[cls][pos] <= val) pos++;
                    for (i = int'(fill[cls]); i > pos; i--) begin
                        held[cls][i] = held[cls][i - 1];
                    end
                    held[cls][pos] = val;
                    fill[cls]++;
                end
            end
            CMD_REMOVE: begin
                pos = -1;
                for (i = 0; i < int'(fill[cls]); i++) begin
                    if (pos < 0 && held[cls][i] == val) pos = i;
                end
                if (pos < 0) begin
                    r.status = STAT_NOT_FOUND;
                end else begin
                    drop_entry(cls, pos);
                end
            end
            CMD_DEQUEUE: begin
                if (fill[CLASS_PRIO] == 0 && fill[CLASS_REGULAR] == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    if (last_was_regular) begin
                        serve_reg = (fill[CLASS_PRIO] == 0);
                    end else begin
                        serve_reg = (fill[CLASS_REGULAR] != 0);
                    end
                    r.out_class = serve_reg;
                    r.out_value = held[serve_reg][0];
                    drop_entry(serve_reg, 0);
                    last_was_regular = serve_reg;
                end
            end
            default: begin
            end
        endcase
        if (fill[CLASS_PRIO] == 0 && fill[CLASS_REGULAR] == 0) last_was_regular = 1'b1;
        r.prio_count = COUNT_W'(fill[CLASS_PRIO]);
        r.reg_count  = COUNT_W'(fill[CLASS_REGULAR]);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill[CLASS_PRIO]    = 0;
            fill[CLASS_REGULAR] = 0;
            last_was_regular    = 1'b1;
            awaited_replies.delete();
        end else begin
            // Results are checked before this edge's command is predicted, so a
            // stray strobe can never match the command transferred at this edge.
            if (i_done !== 1'b0) begin
                if (awaited_replies.size() == 0) begin
                    report_mismatch("result with no command outstanding, value",
                                    i_out_value, 0);
                end else begin
                    oldest = awaited_replies.pop_front();
                    if (i_status !== oldest.status)
                        report_mismatch("status", i_status, oldest.status);
                    if (i_out_class !== oldest.out_class)
                        report_mismatch("out_class", i_out_class, oldest.out_class);
                    if (i_out_value !== oldest.out_value)
                        report_mismatch("out_value", i_out_value, oldest.out_value);
                    if (i_prio_count !== oldest.prio_count)
                        report_mismatch("prio_count", i_prio_count, oldest.prio_count);
                    if (i_reg_count !== oldest.reg_count)
                        report_mismatch("reg_count", i_reg_count, oldest.reg_count);
                end
            end
            if (i_start && i_busy === 1'b0) begin
                awaited_replies.push_back(serve_command(i_cmd, i_req_class, i_req_value));
            end
        end
        o_pending <= awaited_replies.size();
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// Testbench top for two_class_sorted_queue_alternating_unit: clock, reset and
// command stimulus. Checking is done by tcsq_order_checker; uses tcsq_pkg.
module tb;
    import tcsq_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         cmd;
    logic               req_class;
    logic [VALUE_W-1:0] req_value;
    logic               done;
    logic [1:0]         status;
    logic               out_class;
    logic [VALUE_W-1:0] out_value;
    logic [COUNT_W-1:0] prio_count;
    logic [COUNT_W-1:0] reg_count;
    int                 fail_count;
    int                 pending;
    int                 sent;

    two_class_sorted_queue_alternating_unit dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (cmd),
        .i_req_class  (req_class),
        .i_req_value  (req_value),
        .o_done       (done),
        .o_status     (status),
        .o_out_class  (out_class),
        .o_out_value  (out_value),
        .o_prio_count (prio_count),
        .o_reg_count  (reg_count)
    );

    tcsq_order_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (cmd),
        .i_req_class  (req_class),
        .i_req_value  (req_value),
        .i_done       (done),
        .i_status     (status),
        .i_out_class  (out_class),
        .i_out_value  (out_value),
        .i_prio_count (prio_count),
        .i_reg_count  (reg_count),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // Called just after a rising edge; returns just after the edge of the transfer.
    task automatic issue(logic [1:0] c, logic cls, logic [VALUE_W-1:0] v);
        int gap;
        gap = 0;
        if ((sent < 700 || sent >= 1000) && $urandom_range(0, 99) < 23) begin
            gap = $urandom_range(1, 4);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        cmd       <= c;
        req_class <= cls;
        req_value <= v;
        do @(posedge clk); while (busy !== 1'b0);
        sent++;
    endtask

    // Holds the command channel until every predicted result has been seen.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return VALUE_W'($urandom_range(0, 15));
        if (roll < 55) return ($urandom_range(0, 1) != 0) ? '1 : '0;
        return VALUE_W'($urandom());
    endfunction

    initial begin
        int         phase_kind;
        int         roll;
        logic       favored;
        logic [1:0] c;
        logic       cls;
        sent      = 0;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        cmd       <= CMD_INSERT;
        req_class <= CLASS_PRIO;
        req_value <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty service, unused code, extremes, ties, misses,
        // alternation with fallback, and the priority-first restart.
        issue(CMD_DEQUEUE, CLASS_PRIO, '0);
        issue(CMD_UNUSED, CLASS_REGULAR, '1);
        issue(CMD_REMOVE, CLASS_PRIO, 16'h0000);
        issue(CMD_INSERT, CLASS_PRIO, 16'hFFFF);
        issue(CMD_INSERT, CLASS_PRIO, 16'h0000);
        issue(CMD_INSERT, CLASS_PRIO, 16'h0000);
        issue(CMD_INSERT, CLASS_PRIO, 16'h8001);
        issue(CMD_INSERT, CLASS_REGULAR, 16'h8000);
        issue(CMD_INSERT, CLASS_REGULAR, 16'h0000);
        issue(CMD_INSERT, CLASS_REGULAR, 16'hFFFF);
        issue(CMD_REMOVE, CLASS_PRIO, 16'h8000);
        issue(CMD_REMOVE, CLASS_PRIO, 16'h0000);
        issue(CMD_REMOVE, CLASS_REGULAR, 16'h1234);
        repeat (7) issue(CMD_DEQUEUE, CLASS_REGULAR, 16'h5555);
        issue(CMD_INSERT, CLASS_REGULAR, 16'h0005);
        issue(CMD_DEQUEUE, CLASS_PRIO, '0);
        issue(CMD_INSERT, CLASS_REGULAR, 16'h0009);
        issue(CMD_INSERT, CLASS_PRIO, 16'h0007);
        issue(CMD_DEQUEUE, CLASS_PRIO, '0);
        issue(CMD_DEQUEUE, CLASS_PRIO, '0);
        drain_results();

        // Random: phases that fill one class, drain both, or mix.
        favored = CLASS_PRIO;
        for (int n = 0; n < 1800; n++) begin
            if (n % 120 == 0) favored = logic'($urandom_range(0, 1));
            if (n % 500 == 250) drain_results();
            phase_kind = (n / 120) % 3;
            roll = $urandom_range(0, 99);
            if (roll == 0) begin
                c = CMD_UNUSED;
            end else if (phase_kind == 0) begin
                c = (roll < 65) ? CMD_INSERT : (roll < 80) ? CMD_REMOVE : CMD_DEQUEUE;
            end else if (phase_kind == 1) begin
                c = (roll < 20) ? CMD_INSERT : (roll < 40) ? CMD_REMOVE : CMD_DEQUEUE;
            end else begin
                c = (roll < 35) ? CMD_INSERT : (roll < 60) ? CMD_REMOVE : CMD_DEQUEUE;
            end
            cls = ($urandom_range(0, 99) < 80) ? favored : ~favored;
            issue(c, cls, pick_value());
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
